// File: hdl/ffba_pkg.sv
// ---------------------------------------------------------------------------
// ffba_pkg
// Types and constants shared by the first-fit block allocator.
// ---------------------------------------------------------------------------
package ffba_pkg;

    localparam int SIZE_W = 17;
    localparam int ADDR_W = 16;
    localparam int STAT_W = 3;

    localparam logic [SIZE_W-1:0] POOL_RESET = SIZE_W'(1024);
    localparam logic [SIZE_W-1:0] POOL_MAX   = SIZE_W'(65536);

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_NOFIT    = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STAT_W-1:0] ST_ZERO     = 3'd4;

    typedef struct packed {
        logic              req_type;
        logic [SIZE_W-1:0] req_size;
        logic [ADDR_W-1:0] req_address;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ADDR_W-1:0] block_address;
    } t_rsp;

    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_FREE,
        OP_ZERO
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] address;
    } t_cmd;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [SIZE_W-1:0] len;
    } t_ent;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_FRD,
        S_FCHK,
        S_SLOT,
        S_COMMIT,
        S_SHRD,
        S_SHWR,
        S_URD,
        S_UCHK,
        S_DONE
    } t_bstate;

endpackage

// File: hdl/ffba_front.sv
// ---------------------------------------------------------------------------
// ffba_front
// Takes request transfers, classifies them and holds them in a two-entry queue.
// ---------------------------------------------------------------------------
module ffba_front
    import ffba_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_req i_in_data,
    output logic o_in_stall,
    output logic o_cmd_valid,
    output t_cmd o_cmd,
    input  logic i_cmd_pop
);

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_cmd       c_cmd;
    logic       c_push;

    always_comb begin
        c_cmd.size    = i_in_data.req_size;
        c_cmd.address = i_in_data.req_address;
        if (i_in_data.req_type == REQ_FREE) begin
            c_cmd.op = OP_FREE;
        end else if (i_in_data.req_size == '0) begin
            c_cmd.op = OP_ZERO;
        end else begin
            c_cmd.op = OP_ALLOC;
        end
    end

    assign o_in_stall  = (r_cnt == 2'd2);
    assign c_push      = i_in_valid && !o_in_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (c_push) begin
            r_q[r_wp] <= c_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (c_push) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(c_push) - 2'(i_cmd_pop);
        end
    end

    a_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_pop |-> r_cnt != 2'd0)
        else $error("queue popped while empty");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2)
        else $error("queue count above depth");
    a_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wp == (r_rp ^ r_cnt[0]))
        else $error("queue pointers out of step with count");

endmodule

// File: hdl/ffba_back.sv
// ---------------------------------------------------------------------------
// ffba_back
// Executes allocate, free and zero-size commands over the free and used tables.
// ---------------------------------------------------------------------------
module ffba_back
    import ffba_pkg::*;
#(
    parameter int MAX_BLOCKS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_wdata,
    input  logic              i_cmd_valid,
    input  t_cmd              i_cmd,
    output logic              o_cmd_pop,
    output logic              o_out_valid,
    output t_rsp              o_out_data,
    input  logic              i_out_stall
);

    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [CW-1:0] CMAX  = CW'(MAX_BLOCKS);
    localparam logic [CW-1:0] CLAST = CW'(MAX_BLOCKS - 1);

    t_ent free_mem [MAX_BLOCKS];
    t_ent used_mem [MAX_BLOCKS];

    t_bstate           r_state;
    t_bstate           n_state;
    t_cmd              r_cmd;
    logic [CW-1:0]     r_idx;
    logic [CW-1:0]     r_fcnt;
    logic [CW-1:0]     r_ucnt;
    logic [MAX_BLOCKS-1:0] r_uvalid;
    logic [IW-1:0]     r_slot;
    logic              r_slot_ok;
    logic [IW-1:0]     r_fit;
    t_ent              r_fent;
    t_ent              r_frd;
    t_ent              r_urd;
    logic [SIZE_W-1:0] r_pool;
    logic              r_init_pend;
    logic [STAT_W-1:0] r_st;
    logic [ADDR_W-1:0] r_addr;
    logic              r_ovalid;
    t_rsp              r_out;

    logic              c_fwe;
    logic [IW-1:0]     c_fwaddr;
    t_ent              c_fwdata;
    logic [IW-1:0]     c_fraddr;
    logic              c_uwe;
    t_ent              c_uwdata;
    logic              c_out_free;
    logic              c_fits;
    logic              c_exact;
    logic              c_umatch;
    logic [SIZE_W-1:0] c_clamp;
    logic [IW-1:0]     c_idx;
    logic [CW-1:0]     c_idx1;

    assign c_idx      = r_idx[IW-1:0];
    assign c_idx1     = r_idx + CW'(1);
    assign c_out_free = !r_ovalid || !i_out_stall;
    assign c_fits     = (r_frd.len >= r_cmd.size);
    assign c_exact    = (r_fent.len == r_cmd.size);
    assign c_umatch   = (r_urd.start == r_cmd.address);

    always_comb begin
        if (i_cfg_wdata == '0) begin
            c_clamp = SIZE_W'(1);
        end else if (i_cfg_wdata > POOL_MAX) begin
            c_clamp = POOL_MAX;
        end else begin
            c_clamp = i_cfg_wdata;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (r_init_pend) begin
                    n_state = S_INIT;
                end else if (i_cmd_valid) begin
                    unique case (i_cmd.op)
                        OP_ALLOC: n_state = (r_fcnt == '0) ? S_DONE : S_FRD;
                        OP_FREE:  n_state = S_URD;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_INIT: n_state = S_IDLE;
            S_FRD:  n_state = S_FCHK;
            S_FCHK: begin
                if (c_fits) begin
                    if (r_ucnt == CMAX) begin
                        n_state = S_DONE;
                    end else if (r_slot_ok || !r_uvalid[c_idx]) begin
                        n_state = S_COMMIT;
                    end else begin
                        n_state = S_SLOT;
                    end
                end else if (c_idx1 == r_fcnt) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_FRD;
                end
            end
            S_SLOT: begin
                if (!r_uvalid[c_idx]) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (c_exact && (CW'(r_fit) + CW'(1) < r_fcnt)) begin
                    n_state = S_SHRD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SHRD: n_state = S_SHWR;
            S_SHWR: n_state = (r_idx + CW'(2) == r_fcnt) ? S_DONE : S_SHRD;
            S_URD: begin
                if (r_uvalid[c_idx]) begin
                    n_state = S_UCHK;
                end else if (r_idx == CLAST) begin
                    n_state = S_DONE;
                end
            end
            S_UCHK: begin
                if (c_umatch || r_idx == CLAST) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_URD;
                end
            end
            S_DONE: begin
                if (c_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // table port controls
    always_comb begin
        o_cmd_pop = 1'b0;
        c_fwe     = 1'b0;
        c_fwaddr  = c_idx;
        c_fwdata  = r_frd;
        c_fraddr  = c_idx;
        c_uwe     = 1'b0;
        c_uwdata.start = r_fent.start;
        c_uwdata.len   = r_cmd.size;
        unique case (r_state)
            S_IDLE: o_cmd_pop = !r_init_pend && i_cmd_valid;
            S_INIT: begin
                c_fwe          = 1'b1;
                c_fwaddr       = '0;
                c_fwdata.start = '0;
                c_fwdata.len   = r_pool;
            end
            S_COMMIT: begin
                c_uwe = 1'b1;
                if (!c_exact) begin
                    c_fwe          = 1'b1;
                    c_fwaddr       = r_fit;
                    c_fwdata.start = r_fent.start + ADDR_W'(r_cmd.size);
                    c_fwdata.len   = r_fent.len - r_cmd.size;
                end
            end
            S_SHRD: c_fraddr = c_idx1[IW-1:0];
            S_SHWR: c_fwe = 1'b1;
            S_UCHK: begin
                if (c_umatch && r_fcnt != CMAX) begin
                    c_fwe    = 1'b1;
                    c_fwaddr = r_fcnt[IW-1:0];
                    c_fwdata = r_urd;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (c_fwe) begin
            free_mem[c_fwaddr] <= c_fwdata;
        end
        r_frd <= free_mem[c_fraddr];
    end

    always_ff @(posedge i_clk) begin
        if (c_uwe) begin
            used_mem[r_slot] <= c_uwdata;
        end
        r_urd <= used_mem[c_idx];
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_cmd <= i_cmd;
                if (i_cmd.op == OP_FREE) begin
                    r_st <= ST_NOTFOUND;
                end else if (i_cmd.op == OP_ZERO) begin
                    r_st <= ST_ZERO;
                end else begin
                    r_st <= ST_NOFIT;
                end
                r_addr <= '0;
            end
            S_FCHK: begin
                r_fit  <= c_idx;
                r_fent <= r_frd;
                if (c_fits && r_ucnt == CMAX) begin
                    r_st <= ST_FULL;
                end
                if (!r_slot_ok && !r_uvalid[c_idx]) begin
                    r_slot <= c_idx;
                end
            end
            S_SLOT: r_slot <= c_idx;
            S_COMMIT: begin
                r_st   <= ST_OK;
                r_addr <= r_fent.start;
            end
            S_UCHK: begin
                if (c_umatch) begin
                    r_st <= (r_fcnt == CMAX) ? ST_FULL : ST_OK;
                end
            end
            default: ;
        endcase
        if (r_state == S_DONE && c_out_free) begin
            r_out.status        <= r_st;
            r_out.block_address <= r_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_fcnt      <= '0;
            r_ucnt      <= '0;
            r_uvalid    <= '0;
            r_slot_ok   <= 1'b0;
            r_pool      <= POOL_RESET;
            r_init_pend <= 1'b1;
            r_ovalid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_pool      <= c_clamp;
                r_init_pend <= 1'b1;
            end else if (r_state == S_INIT) begin
                r_init_pend <= 1'b0;
            end
            if (r_state == S_DONE && c_out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_idx     <= '0;
                    r_slot_ok <= 1'b0;
                end
                S_INIT: begin
                    r_fcnt   <= CW'(1);
                    r_ucnt   <= '0;
                    r_uvalid <= '0;
                end
                S_FRD: ;
                S_FCHK: begin
                    if (!r_slot_ok && !r_uvalid[c_idx]) begin
                        r_slot_ok <= 1'b1;
                    end
                    if (c_fits) begin
                        r_idx <= c_idx1;
                    end else begin
                        r_idx <= c_idx1;
                    end
                end
                S_SLOT: begin
                    if (r_uvalid[c_idx]) begin
                        r_idx <= c_idx1;
                    end
                end
                S_COMMIT: begin
                    r_uvalid[r_slot] <= 1'b1;
                    r_ucnt           <= r_ucnt + CW'(1);
                    r_idx            <= CW'(r_fit);
                    if (c_exact && !(CW'(r_fit) + CW'(1) < r_fcnt)) begin
                        r_fcnt <= r_fcnt - CW'(1);
                    end
                end
                S_SHRD: ;
                S_SHWR: begin
                    r_idx <= c_idx1;
                    if (r_idx + CW'(2) == r_fcnt) begin
                        r_fcnt <= r_fcnt - CW'(1);
                    end
                end
                S_URD: begin
                    if (!r_uvalid[c_idx] && r_idx != CLAST) begin
                        r_idx <= c_idx1;
                    end
                end
                S_UCHK: begin
                    if (c_umatch) begin
                        if (r_fcnt != CMAX) begin
                            r_fcnt          <= r_fcnt + CW'(1);
                            r_uvalid[c_idx] <= 1'b0;
                            r_ucnt          <= r_ucnt - CW'(1);
                        end
                    end else if (r_idx != CLAST) begin
                        r_idx <= c_idx1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    a_ucnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ucnt == CW'($countones(r_uvalid)))
        else $error("used count out of step with valid bits");
    a_fcnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fcnt <= CMAX)
        else $error("free count above table depth");
    a_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SLOT |-> r_ucnt != CMAX)
        else $error("slot search with full used table");
    a_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_COMMIT |-> !r_uvalid[r_slot])
        else $error("commit into a live used slot");

endmodule

// File: hdl/first_fit_block_allocator.sv
// ---------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator over one pool with free and used descriptor tables.
// ---------------------------------------------------------------------------
//  channel   valid         stall         payload
//  request   i_in_valid    o_in_stall    i_in_data  (t_req)
//  result    o_out_valid   i_out_stall   o_out_data (t_rsp)
//  config    i_cfg_we      -             i_cfg_wdata (pool_size)
//
//  Allocate: reads and checks free descriptors in turn, searches further used
//  slots as needed, commits, and shifts entries if an exact fit closes a hole.
//  Free: reads each used slot in turn and checks the address of each live one.
//  Every request also passes a dispatch state and a result state.
//  Reset or a pool_size write rebuilds the tables in the S_INIT state.
//  A two-entry queue lets requests enter while a result is stalled.
// ---------------------------------------------------------------------------
module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int MAX_BLOCKS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_wdata,
    input  logic              i_in_valid,
    input  t_req              i_in_data,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output t_rsp              o_out_data,
    input  logic              i_out_stall
);

    logic cmd_valid;
    t_cmd cmd;
    logic cmd_pop;

    ffba_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    ffba_back #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule
